// File: rtl/chw_pkg.sv
// Package for the compass heading wedge: sizes, codes, item types and angle tables.
package chw_pkg;

	localparam int FIELD_WIDTH  = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int STEP_W       = $clog2(TABLE_LEN);
	localparam int YAW_W        = 16;
	localparam int MID_W        = FIELD_WIDTH + 1;
	localparam int CORDIC_W     = FIELD_WIDTH + 12;
	localparam int ANG_W        = 32;
	localparam int OFS_W        = 12;
	localparam int SPAN_W       = 16;
	localparam int WEDGE_W      = 4;
	localparam int RED_STEPS    = 2 + WEDGE_W;
	localparam int RED_W        = $clog2(RED_STEPS);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int IN_W         = ((1 + YAW_W + 3 * FIELD_WIDTH + 7) / 8) * 8;
	localparam int OUT_BITS     = 2 + YAW_W + WEDGE_W;
	localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = 1;
	localparam int QCNT_W       = 2;

	// angles in 1/655360 degree
	localparam logic signed [ANG_W-1:0] FULL_TURN  = 32'sd235929600;
	localparam logic signed [ANG_W-1:0] HALF_TURN  = 32'sd117964800;
	localparam logic signed [ANG_W-1:0] TWO_TURNS  = 32'sd471859200;
	localparam logic signed [ANG_W-1:0] WEDGE_SIZE = 32'sd14745600;

	localparam logic signed [YAW_W-1:0] YAW_MIN = {1'b1, {(YAW_W-1){1'b0}}};
	localparam logic signed [YAW_W-1:0] YAW_MAX = {1'b0, {(YAW_W-1){1'b1}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMU_ENABLED,
		REG_YAW_NEGATE,
		REG_HEADING_OFFSET,
		REG_SPAN_MINIMUM
	} cfg_reg_t;

	typedef struct packed {
		logic              imu_enabled;
		logic              yaw_negate;
		logic [OFS_W-1:0]  heading_offset;
		logic [SPAN_W-1:0] span_minimum;
	} cfg_t;

	typedef enum logic [1:0] {
		ITEM_DISABLED,
		ITEM_HOLD,
		ITEM_FRESH
	} item_kind_t;

	typedef struct packed {
		item_kind_t               kind;
		logic                     mag_ok;
		logic signed [YAW_W-1:0]  yaw;
		logic signed [MID_W-1:0]  mid_x;
		logic signed [MID_W-1:0]  mid_y;
	} q_entry_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ROTATE,
		B_REDUCE,
		B_DONE
	} back_state_t;

	// atan(2^-i), rounded
	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic signed [ANG_W-1:0] a;
		unique case (i)
			5'd0:    a = 32'sd29491200;
			5'd1:    a = 32'sd17409672;
			5'd2:    a = 32'sd9198793;
			5'd3:    a = 32'sd4669451;
			5'd4:    a = 32'sd2343786;
			5'd5:    a = 32'sd1173036;
			5'd6:    a = 32'sd586661;
			5'd7:    a = 32'sd293348;
			5'd8:    a = 32'sd146676;
			5'd9:    a = 32'sd73339;
			5'd10:   a = 32'sd36669;
			5'd11:   a = 32'sd18335;
			5'd12:   a = 32'sd9167;
			5'd13:   a = 32'sd4584;
			5'd14:   a = 32'sd2292;
			5'd15:   a = 32'sd1146;
			5'd16:   a = 32'sd573;
			5'd17:   a = 32'sd286;
			5'd18:   a = 32'sd143;
			5'd19:   a = 32'sd72;
			5'd20:   a = 32'sd36;
			5'd21:   a = 32'sd18;
			5'd22:   a = 32'sd9;
			5'd23:   a = 32'sd4;
			default: a = '0;
		endcase
		return a;
	endfunction

	// restoring steps: two for the turn wrap, then one per wedge bit
	function automatic logic signed [ANG_W-1:0] reduce_divisor(input logic [RED_W-1:0] r);
		logic signed [ANG_W-1:0] d;
		unique case (r)
			3'd0:    d = FULL_TURN <<< 1;
			3'd1:    d = FULL_TURN;
			3'd2:    d = WEDGE_SIZE <<< 3;
			3'd3:    d = WEDGE_SIZE <<< 2;
			3'd4:    d = WEDGE_SIZE <<< 1;
			3'd5:    d = WEDGE_SIZE;
			default: d = FULL_TURN;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/compass_heading_wedge_top.sv
// Top level of the compass heading wedge: configuration registers, front end, queue and back end.
//
// One result per input request. The front end takes a request whenever the two-entry queue has
// room, and updates the x/y extremes at once. A request that needs a heading is loaded into the
// back end, runs the CORDIC iterations on the shared shift-add unit, then six restoring
// compare-subtract steps for the turn wrap and the four wedge bits, and is written to the
// output register once that is free. Requests without a heading (IMU disabled, no fresh sample,
// zero reading, spans too small, zero centred vector) pass from the queue straight to the output
// register once it is free. The output register holds a result until it is taken while the
// front end keeps filling the queue. Configuration writes are taken every cycle and must be made
// only while no request is in flight.
module compass_heading_wedge_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [chw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [chw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// new_sample[0], gyro_yaw[16:1], field_x[32:17], field_y[48:33], field_z[64:49]
	input  logic [chw_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// imu_ok[0], yaw_rate[16:1], mag_ok[17], heading_wedge[21:18]
	output logic [chw_pkg::OUT_W-1:0]     m_tdata
);
	import chw_pkg::*;

	cfg_t     cfg_q;
	logic     push_valid, push_ready, pop_valid, pop_ready;
	q_entry_t push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.imu_enabled    <= 1'b1;
			cfg_q.yaw_negate     <= 1'b0;
			cfg_q.heading_offset <= '0;
			cfg_q.span_minimum   <= SPAN_W'(5);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMU_ENABLED:    cfg_q.imu_enabled    <= cfg_data[0];
				REG_YAW_NEGATE:     cfg_q.yaw_negate     <= cfg_data[0];
				REG_HEADING_OFFSET: cfg_q.heading_offset <= cfg_data[OFS_W-1:0];
				REG_SPAN_MINIMUM:   cfg_q.span_minimum   <= cfg_data[SPAN_W-1:0];
				default:            cfg_q.imu_enabled    <= cfg_q.imu_enabled;
			endcase
		end
	end

	chw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	chw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	chw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef SYNTH
	a_mag_needs_imu: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2+YAW_W-1] |-> m_tdata[0])
		else $error("mag_ok without imu_ok");

	a_wedge_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2+YAW_W-1] |-> (m_tdata[OUT_BITS-1:2+YAW_W] == '0))
		else $error("wedge set without mag_ok");

	a_pop_when_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready |-> pop_valid)
		else $error("queue popped while empty");
`endif

endmodule

// File: rtl/chw_front.sv
// Front end: takes polls, tracks field extremes, centres the vector and classifies the item.
module chw_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  chw_pkg::cfg_t             cfg,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [chw_pkg::IN_W-1:0]  s_tdata,
	output logic                      push_valid,
	input  logic                      push_ready,
	output chw_pkg::q_entry_t         push_data
);
	import chw_pkg::*;

	localparam logic signed [FIELD_WIDTH-1:0] F_MAX = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
	localparam logic signed [FIELD_WIDTH-1:0] F_MIN = {1'b1, {(FIELD_WIDTH-1){1'b0}}};

	logic                          new_sample;
	logic signed [YAW_W-1:0]       yaw_in;
	logic signed [YAW_W-1:0]       yaw_out;
	logic signed [FIELD_WIDTH-1:0] fx, fy, fz;
	logic signed [FIELD_WIDTH-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic signed [FIELD_WIDTH-1:0] nmin_x, nmax_x, nmin_y, nmax_y;
	logic signed [MID_W-1:0]       sum_x, sum_y, mid_x, mid_y;
	logic [MID_W-1:0]              span_x, span_y;
	logic                          nonzero, mag_ok, accept, update;

	assign new_sample = s_tdata[0];
	assign yaw_in     = s_tdata[YAW_W:1];
	assign fx         = s_tdata[YAW_W+FIELD_WIDTH:YAW_W+1];
	assign fy         = s_tdata[YAW_W+2*FIELD_WIDTH:YAW_W+FIELD_WIDTH+1];
	assign fz         = s_tdata[YAW_W+3*FIELD_WIDTH:YAW_W+2*FIELD_WIDTH+1];

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;
	assign accept     = s_tvalid && push_ready;

	always_comb begin
		nonzero = (fx != '0) || (fy != '0) || (fz != '0);
		nmin_x  = (fx < min_x_q) ? fx : min_x_q;
		nmax_x  = (fx > max_x_q) ? fx : max_x_q;
		nmin_y  = (fy < min_y_q) ? fy : min_y_q;
		nmax_y  = (fy > max_y_q) ? fy : max_y_q;
		sum_x   = MID_W'(nmin_x) + MID_W'(nmax_x);
		sum_y   = MID_W'(nmin_y) + MID_W'(nmax_y);
		mid_x   = {fx, 1'b0} - sum_x;
		mid_y   = {fy, 1'b0} - sum_y;
		span_x  = MID_W'(nmax_x) - MID_W'(nmin_x);
		span_y  = MID_W'(nmax_y) - MID_W'(nmin_y);
		mag_ok  = nonzero && (span_x > MID_W'(cfg.span_minimum))
			&& (span_y > MID_W'(cfg.span_minimum)) && ((mid_x != '0) || (mid_y != '0));
		if (!cfg.yaw_negate) begin
			yaw_out = yaw_in;
		end else if (yaw_in == YAW_MIN) begin
			yaw_out = YAW_MAX;
		end else begin
			yaw_out = -yaw_in;
		end
		if (!cfg.imu_enabled) begin
			push_data.kind = ITEM_DISABLED;
		end else if (!new_sample) begin
			push_data.kind = ITEM_HOLD;
		end else begin
			push_data.kind = ITEM_FRESH;
		end
		push_data.mag_ok = mag_ok;
		push_data.yaw    = yaw_out;
		push_data.mid_x  = mid_x;
		push_data.mid_y  = mid_y;
		update = accept && cfg.imu_enabled && new_sample && nonzero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= F_MAX;
			max_x_q <= F_MIN;
			min_y_q <= F_MAX;
			max_y_q <= F_MIN;
		end else if (update) begin
			min_x_q <= nmin_x;
			max_x_q <= nmax_x;
			min_y_q <= nmin_y;
			max_y_q <= nmax_y;
		end
	end

endmodule

// File: rtl/chw_queue.sv
// Short queue of classified items between the front and back ends.
module chw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  chw_pkg::q_entry_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output chw_pkg::q_entry_t pop_data
);
	import chw_pkg::*;

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push, pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/chw_back.sv
// Back end: iterative CORDIC heading, turn wrap and wedge steps, held result and output register.
module chw_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  chw_pkg::cfg_t             cfg,
	input  logic                      pop_valid,
	output logic                      pop_ready,
	input  chw_pkg::q_entry_t         pop_data,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [chw_pkg::OUT_W-1:0] m_tdata
);
	import chw_pkg::*;

	back_state_t                state_q, state_d;
	logic signed [CORDIC_W-1:0] x_q, y_q, x_ld, y_ld, x_step, y_step, sx, sy;
	logic signed [ANG_W-1:0]    z_q, z_ld, z_step, z_sum, z_red, ang, div;
	logic [STEP_W-1:0]          step_q;
	logic [RED_W-1:0]           red_q;
	logic [WEDGE_W-1:0]         wedge_acc_q;
	logic signed [YAW_W-1:0]    yaw_q;
	logic                       held_imu_ok_q, held_mag_ok_q, out_valid_q;
	logic signed [YAW_W-1:0]    held_yaw_q;
	logic [WEDGE_W-1:0]         held_wedge_q;
	logic                       out_free, load, write_res, res_hold, ge, last_step, last_red;
	logic                       res_imu_ok, res_mag_ok;
	logic signed [YAW_W-1:0]    res_yaw;
	logic [WEDGE_W-1:0]         res_wedge;

	assign out_free  = !out_valid_q || m_tready;
	assign last_step = (step_q == STEP_W'(CORDIC_STEPS - 1));
	assign last_red  = (red_q == RED_W'(RED_STEPS - 1));
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(OUT_W-OUT_BITS){1'b0}}, held_wedge_q, held_mag_ok_q,
		held_yaw_q, held_imu_ok_q};

	// datapath
	always_comb begin
		x_ld = CORDIC_W'(pop_data.mid_x) <<< 8;
		y_ld = CORDIC_W'(pop_data.mid_y) <<< 8;
		z_ld = '0;
		if (pop_data.mid_x < 0) begin
			x_ld = -x_ld;
			y_ld = -y_ld;
			z_ld = HALF_TURN;
		end
		sx  = x_q >>> step_q;
		sy  = y_q >>> step_q;
		ang = atan_entry(step_q);
		if (y_q >= 0) begin
			x_step = x_q + sy;
			y_step = y_q - sx;
			z_step = z_q + ang;
		end else begin
			x_step = x_q - sy;
			y_step = y_q + sx;
			z_step = z_q - ang;
		end
		z_sum = z_step + ANG_W'({cfg.heading_offset, 16'd0}) + TWO_TURNS;
		div   = reduce_divisor(red_q);
		ge    = (z_q >= div);
		z_red = ge ? (z_q - div) : z_q;
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		pop_ready  = 1'b0;
		load       = 1'b0;
		write_res  = 1'b0;
		res_hold   = 1'b0;
		res_imu_ok = 1'b0;
		res_yaw    = '0;
		res_mag_ok = 1'b0;
		res_wedge  = '0;
		unique case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					if (pop_data.kind == ITEM_FRESH && pop_data.mag_ok) begin
						pop_ready = 1'b1;
						load      = 1'b1;
						state_d   = B_ROTATE;
					end else if (out_free) begin
						pop_ready = 1'b1;
						write_res = 1'b1;
						unique case (pop_data.kind)
							ITEM_DISABLED: res_imu_ok = 1'b0;
							ITEM_HOLD:     res_hold = 1'b1;
							default: begin
								res_imu_ok = 1'b1;
								res_yaw    = pop_data.yaw;
							end
						endcase
					end
				end
			end
			B_ROTATE: begin
				if (last_step) begin
					state_d = B_REDUCE;
				end
			end
			B_REDUCE: begin
				if (last_red) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (out_free) begin
					write_res  = 1'b1;
					res_imu_ok = 1'b1;
					res_yaw    = yaw_q;
					res_mag_ok = 1'b1;
					res_wedge  = wedge_acc_q;
					state_d    = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q   <= x_ld;
			y_q   <= y_ld;
			z_q   <= z_ld;
			yaw_q <= pop_data.yaw;
		end else if (state_q == B_ROTATE) begin
			x_q <= x_step;
			y_q <= y_step;
			z_q <= last_step ? z_sum : z_step;
		end else if (state_q == B_REDUCE) begin
			z_q <= z_red;
			if (red_q >= RED_W'(2)) begin
				wedge_acc_q <= {wedge_acc_q[WEDGE_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			step_q        <= '0;
			red_q         <= '0;
			out_valid_q   <= 1'b0;
			held_imu_ok_q <= 1'b0;
			held_yaw_q    <= '0;
			held_mag_ok_q <= 1'b0;
			held_wedge_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= '0;
			end else if (state_q == B_ROTATE) begin
				step_q <= step_q + 1'b1;
			end
			if (state_q == B_ROTATE) begin
				red_q <= '0;
			end else if (state_q == B_REDUCE) begin
				red_q <= red_q + 1'b1;
			end
			if (write_res) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (write_res && !res_hold) begin
				held_imu_ok_q <= res_imu_ok;
				held_yaw_q    <= res_yaw;
				held_mag_ok_q <= res_mag_ok;
				held_wedge_q  <= res_wedge;
			end
		end
	end

endmodule

// File: test/compass_heading_wedge_checker.sv
// Checker for the compass heading wedge: tracks settings, predicts each poll's result and compares.
module compass_heading_wedge_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [chw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [chw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// new_sample[0], gyro_yaw[16:1], field_x[32:17], field_y[48:33], field_z[64:49]
	input  logic [chw_pkg::IN_W-1:0]       s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// imu_ok[0], yaw_rate[16:1], mag_ok[17], heading_wedge[21:18]
	input  logic [chw_pkg::OUT_W-1:0]      m_tdata,
	output int                             fail_count,
	output int                             pending,
	output int                             heading_count,
	output logic [15:0]                    wedges_hit
);
	timeunit 1ns;
	timeprecision 1ps;
	import chw_pkg::*;

	localparam longint TURN_UNITS  = 64'd3600 * 64'd65536;
	localparam longint HALF_UNITS  = 64'd1800 * 64'd65536;
	localparam longint WEDGE_UNITS = 64'd225 * 64'd65536;
	localparam logic signed [FIELD_WIDTH-1:0] FIELD_TOP    = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
	localparam logic signed [FIELD_WIDTH-1:0] FIELD_BOTTOM = {1'b1, {(FIELD_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic                    imu_ok;
		logic signed [YAW_W-1:0] yaw;
		logic                    mag_ok;
		logic [WEDGE_W-1:0]      wedge;
	} poll_result_t;

	logic                          imu_en, yaw_inv;
	logic [OFS_W-1:0]              offset;
	logic [SPAN_W-1:0]             span_min;
	logic signed [FIELD_WIDTH-1:0] lo_x, hi_x, lo_y, hi_y;
	poll_result_t                  held;
	poll_result_t                  expected_results[$];
	int                            errors, headings;
	logic [15:0]                   hit_mask;

	// atan(2^-i) in 1/655360 degree
	function automatic longint arctan_step(input int i);
		case (i)
			0:  return 29491200;
			1:  return 17409672;
			2:  return 9198793;
			3:  return 4669451;
			4:  return 2343786;
			5:  return 1173036;
			6:  return 586661;
			7:  return 293348;
			8:  return 146676;
			9:  return 73339;
			10: return 36669;
			11: return 18335;
			12: return 9167;
			13: return 4584;
			14: return 2292;
			15: return 1146;
			16: return 573;
			17: return 286;
			18: return 143;
			19: return 72;
			20: return 36;
			21: return 18;
			22: return 9;
			23: return 4;
			default: return 0;
		endcase
	endfunction

	function automatic logic [WEDGE_W-1:0] wedge_of_vector(input longint cx, input longint cy,
			input logic [OFS_W-1:0] ofs);
		longint x, y, z, nx, ny;
		int     i;
		x = cx * 256;
		y = cy * 256;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = HALF_UNITS;
		end
		for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z  = z + arctan_step(i);
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z  = z - arctan_step(i);
			end
			x = nx;
			y = ny;
		end
		z = (z + longint'(ofs) * 65536 + 2 * TURN_UNITS) % TURN_UNITS;
		return WEDGE_W'(z / WEDGE_UNITS);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		poll_result_t                  want, got;
		logic signed [YAW_W-1:0]       yaw;
		logic signed [FIELD_WIDTH-1:0] fx, fy, fz;
		longint                        cx, cy;
		if (!arst_n) begin
			imu_en   = 1'b1;
			yaw_inv  = 1'b0;
			offset   = '0;
			span_min = 16'd5;
			lo_x     = FIELD_TOP;
			lo_y     = FIELD_TOP;
			hi_x     = FIELD_BOTTOM;
			hi_y     = FIELD_BOTTOM;
			held     = '0;
			expected_results.delete();
			errors   = 0;
			headings = 0;
			hit_mask = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMU_ENABLED:    imu_en   = cfg_data[0];
					REG_YAW_NEGATE:     yaw_inv  = cfg_data[0];
					REG_HEADING_OFFSET: offset   = cfg_data[OFS_W-1:0];
					REG_SPAN_MINIMUM:   span_min = cfg_data[SPAN_W-1:0];
					default: ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				got.imu_ok = m_tdata[0];
				got.yaw    = m_tdata[16:1];
				got.mag_ok = m_tdata[17];
				got.wedge  = m_tdata[21:18];
				if (expected_results.size() == 0) begin
					$error("result %h arrived with nothing outstanding", m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.imu_ok !== want.imu_ok) begin
						$error("imu_ok: expected %0d, got %0d", want.imu_ok, got.imu_ok);
						errors++;
					end
					if (got.yaw !== want.yaw) begin
						$error("yaw_rate: expected %0d, got %0d", want.yaw, got.yaw);
						errors++;
					end
					if (got.mag_ok !== want.mag_ok) begin
						$error("mag_ok: expected %0d, got %0d", want.mag_ok, got.mag_ok);
						errors++;
					end
					if (got.wedge !== want.wedge) begin
						$error("heading_wedge: expected %0d, got %0d", want.wedge, got.wedge);
						errors++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				if (!imu_en) begin
					held = '0;
				end else if (s_tdata[0]) begin
					yaw = s_tdata[16:1];
					fx  = s_tdata[32:17];
					fy  = s_tdata[48:33];
					fz  = s_tdata[64:49];
					if (yaw_inv)
						yaw = (yaw == YAW_MIN) ? YAW_MAX : -yaw;
					held.imu_ok = 1'b1;
					held.yaw    = yaw;
					held.mag_ok = 1'b0;
					held.wedge  = '0;
					// an all-zero reading leaves the extremes alone
					if (fx != 0 || fy != 0 || fz != 0) begin
						if (fx < lo_x) lo_x = fx;
						if (fx > hi_x) hi_x = fx;
						if (fy < lo_y) lo_y = fy;
						if (fy > hi_y) hi_y = fy;
						cx = 2 * longint'(fx) - longint'(lo_x) - longint'(hi_x);
						cy = 2 * longint'(fy) - longint'(lo_y) - longint'(hi_y);
						if (longint'(hi_x) - longint'(lo_x) > longint'(span_min) &&
								longint'(hi_y) - longint'(lo_y) > longint'(span_min) &&
								(cx != 0 || cy != 0)) begin
							held.mag_ok = 1'b1;
							held.wedge  = wedge_of_vector(cx, cy, offset);
							headings++;
							hit_mask[held.wedge] = 1'b1;
						end
					end
				end
				expected_results.push_back(held);
			end
		end
		fail_count    <= errors;
		pending       <= expected_results.size();
		heading_count <= headings;
		wedges_hit    <= hit_mask;
	end

endmodule

// File: test/compass_heading_wedge_top_tb.sv
// Testbench top for the compass heading wedge: clock, reset, settings, poll stimulus and verdict.
module compass_heading_wedge_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import chw_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic                  clk, arst_n;
	logic                  cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid, s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  m_tvalid, m_tready;
	logic [OUT_W-1:0]      m_tdata;

	int          fail_count, pending, heading_count;
	logic [15:0] wedges_hit;
	int          src_idle_pct, snk_stall_pct, hold_left;
	bit          hold_off_req, hold_done;
	int          polls_sent, settings_used;
	longint      cycles;

	compass_heading_wedge_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	compass_heading_wedge_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.heading_count (heading_count),
		.wedges_hit    (wedges_hit)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		hold_left = 0;
		hold_done = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	task automatic set_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(input logic en, input logic inv, input logic [OFS_W-1:0] ofs,
			input logic [SPAN_W-1:0] span);
		set_reg(REG_IMU_ENABLED, CFG_DATA_W'(en));
		set_reg(REG_YAW_NEGATE, CFG_DATA_W'(inv));
		set_reg(REG_HEADING_OFFSET, CFG_DATA_W'(ofs));
		set_reg(REG_SPAN_MINIMUM, span);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic send_poll(input logic ns, input logic [15:0] yaw, input logic [15:0] fx,
			input logic [15:0] fy, input logic [15:0] fz);
		int gap = 0;
		while (gap < 40 && $urandom_range(99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({fz, fy, fx, yaw, ns});
		do @(posedge clk); while (!s_tready);
		polls_sent++;
	endtask

	// stop offering and wait until every request has produced its result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic random_poll();
		logic [15:0] yaw, fx, fy, fz;
		int          kind;
		kind = $urandom_range(99);
		yaw  = 16'($urandom);
		fx   = 16'($urandom);
		fy   = 16'($urandom);
		fz   = 16'($urandom);
		if (kind >= 8 && kind < 13) begin
			fx = '0;
			fy = '0;
			fz = '0;
		end else if (kind >= 13 && kind < 40) begin
			fx = 16'($urandom_range(600)) - 16'd300;
			fy = 16'($urandom_range(600)) - 16'd300;
		end
		if (kind >= 95)
			yaw = kind[0] ? 16'h8000 : 16'h7fff;
		send_poll(kind >= 8, yaw, fx, fy, fz);
	endtask

	initial begin
		int phase, n;
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_IMU_ENABLED;
		cfg_data      <= '0;
		s_tvalid      <= 1'b0;
		s_tdata       <= '0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_off_req  = 1'b0;
		polls_sent    = 0;
		settings_used = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: held zeros, zero reading, small spans, zero vector
		send_poll(1'b0, 16'h1234, 16'd5, 16'd5, 16'd5);
		send_poll(1'b1, 16'h8000, 16'd0, 16'd0, 16'd0);
		send_poll(1'b1, 16'h7fff, -16'sd10, -16'sd10, 16'd0);
		send_poll(1'b1, 16'h0000, 16'd10, 16'd10, 16'd0);
		send_poll(1'b1, 16'h0001, 16'd0, 16'd0, 16'h8000);
		send_poll(1'b1, 16'hffff, 16'd3, 16'd0, 16'd0);
		// full-scale extremes, then a walk round the circle
		send_poll(1'b1, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff);
		send_poll(1'b1, 16'h0002, 16'h8000, 16'h7fff, 16'd0);
		send_poll(1'b1, 16'h0100, 16'd1000, 16'd0, 16'd1);
		send_poll(1'b1, 16'h0100, 16'd707, 16'd707, 16'd1);
		send_poll(1'b1, 16'h0100, 16'd0, 16'd1000, 16'd1);
		send_poll(1'b1, 16'h0100, -16'sd707, 16'd707, 16'd1);
		send_poll(1'b1, 16'h0100, -16'sd1000, 16'd0, 16'd1);
		send_poll(1'b1, 16'h0100, -16'sd707, -16'sd707, 16'd1);
		send_poll(1'b1, 16'h0100, 16'd0, -16'sd1000, 16'd1);
		send_poll(1'b1, 16'h0100, 16'd707, -16'sd707, 16'd1);
		send_poll(1'b1, 16'h0100, -16'sd1, 16'd0, 16'd1);
		drain_results();

		// inverted yaw with saturation, span never met
		apply_settings(1'b1, 1'b1, 12'd3599, 16'hffff);
		send_poll(1'b1, 16'h8000, 16'd500, 16'd200, 16'd0);
		send_poll(1'b1, 16'h7fff, -16'sd300, 16'd100, 16'd0);
		send_poll(1'b1, 16'h0001, 16'd1, 16'd1, 16'd1);
		drain_results();

		// offset beyond a full turn, zero span minimum
		apply_settings(1'b1, 1'b0, 12'hfff, 16'h0000);
		send_poll(1'b1, 16'h0040, 16'd1200, -16'sd400, 16'd0);
		send_poll(1'b1, 16'hffc0, -16'sd900, 16'd900, 16'd0);
		drain_results();

		// IMU absent
		apply_settings(1'b0, 1'b1, 12'd900, 16'd5);
		send_poll(1'b1, 16'h4000, 16'd800, 16'd800, 16'd800);
		send_poll(1'b0, 16'h4000, 16'd0, 16'd0, 16'd0);

		for (phase = 0; phase < 4; phase++) begin
			drain_results();
			if (phase == 2) begin
				apply_settings(1'b0, 1'b0, 12'd0, 16'd5);
				for (n = 0; n < 15; n++)
					random_poll();
				drain_results();
			end
			case (phase)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
				default: begin src_idle_pct = 35; snk_stall_pct = 35; end
			endcase
			apply_settings(1'b1, 1'($urandom_range(1)), 12'($urandom_range(4095)),
				(phase == 3) ? 16'hfffe : 16'($urandom_range(300)));
			for (n = 0; n < 125; n++) begin
				if (phase == 0 && n == 40)
					hold_off_req = 1'b1;
				if (phase == 1 && n == 60)
					drain_results();
				random_poll();
			end
		end

		drain_results();
		repeat (30) @(posedge clk);
		$display("Summary: %0d polls over %0d register settings, %0d headings, wedge mask %h",
			polls_sent, settings_used, heading_count, wedges_hit);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
